### hdl/mtu_pkg.sv
// Shared types, constants and helpers of the 4x4 matrix transform unit.
package mtu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned Dim    = 4;
  localparam int unsigned EntryN = Dim * Dim;
  localparam int unsigned ProdW  = 2 * DataW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned TermW  = ProdW - FracW;
  localparam int unsigned PairW  = TermW + 1;
  localparam int unsigned AccW   = TermW + 2;
  localparam int unsigned CntW   = 4;

  localparam logic signed [DataW-1:0] QOne = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = -32'sh7FFF_FFFF - 32'sh1;

  typedef enum logic [2:0] {
    KIND_WR_CUR = 3'd0,
    KIND_WR_OP  = 3'd1,
    KIND_MMUL   = 3'd2,
    KIND_XFORM  = 3'd3,
    KIND_IDENT  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_XFORM = 4'b0010,
    S_MMUL  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  typedef struct packed {
    logic load_vec;
    logic wr_cur;
    logic wr_op;
    logic ident;
    logic issue;
    logic xform;
    logic first;
    logic last;
    logic copy;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(QMax);
    lo = AccW'(QMin);
    if (s > hi) begin
      return QMax;
    end else if (s < lo) begin
      return QMin;
    end
    return s[DataW-1:0];
  endfunction

endpackage

### hdl/mtu_ctrl.sv
// Sequencing controller of the 4x4 matrix transform unit.
module mtu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        kind,
  output logic              out_valid,
  input  logic              out_ready,
  output mtu_pkg::dp_cmd_t  cmd,
  input  mtu_pkg::dp_stat_t stat
);

  mtu_pkg::state_t             state, state_next;
  logic [mtu_pkg::CntW-1:0]    cnt, cnt_next;
  logic                        is_x, is_x_next;
  logic                        out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    is_x_next  = is_x;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      mtu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (kind)
            mtu_pkg::KIND_WR_CUR: cmd.wr_cur = 1'b1;
            mtu_pkg::KIND_WR_OP:  cmd.wr_op  = 1'b1;
            mtu_pkg::KIND_IDENT:  cmd.ident  = 1'b1;
            mtu_pkg::KIND_XFORM: begin
              cmd.load_vec = 1'b1;
              cnt_next     = '0;
              is_x_next    = 1'b1;
              state_next   = mtu_pkg::S_XFORM;
            end
            mtu_pkg::KIND_MMUL: begin
              cnt_next   = '0;
              is_x_next  = 1'b0;
              state_next = mtu_pkg::S_MMUL;
            end
            default: ;
          endcase
        end
      end
      mtu_pkg::S_XFORM: begin
        cmd.issue = 1'b1;
        cmd.xform = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt[1:0] == 2'd3) begin
          state_next = mtu_pkg::S_DRAIN;
        end
      end
      mtu_pkg::S_MMUL: begin
        cmd.issue = 1'b1;
        cmd.first = (cnt[1:0] == 2'd0);
        cmd.last  = (cnt[1:0] == 2'd3);
        cnt_next  = cnt + 1'b1;
        if (cnt == 4'd15) begin
          state_next = mtu_pkg::S_DRAIN;
        end
      end
      mtu_pkg::S_DRAIN: begin
        if (!stat.busy) begin
          if (is_x) begin
            if (!out_valid || out_ready) begin
              cmd.publish = 1'b1;
              state_next  = mtu_pkg::S_IDLE;
            end
          end else begin
            cmd.copy   = 1'b1;
            state_next = mtu_pkg::S_IDLE;
          end
        end
      end
      default: state_next = mtu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtu_pkg::S_IDLE;
      cnt       <= '0;
      is_x      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      is_x      <= is_x_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/mtu_datapath.sv
// Matrix storage, four multiplier lanes, accumulators and result registers.
module mtu_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mtu_pkg::dp_cmd_t                    cmd,
  output mtu_pkg::dp_stat_t                   stat,
  input  logic [3:0]                          entry_index,
  input  logic signed [mtu_pkg::DataW-1:0]    entry_value,
  input  logic signed [mtu_pkg::DataW-1:0]    vec_x,
  input  logic signed [mtu_pkg::DataW-1:0]    vec_y,
  input  logic signed [mtu_pkg::DataW-1:0]    vec_z,
  input  logic signed [mtu_pkg::DataW-1:0]    vec_w,
  output logic signed [mtu_pkg::DataW-1:0]    out_x,
  output logic signed [mtu_pkg::DataW-1:0]    out_y,
  output logic signed [mtu_pkg::DataW-1:0]    out_z,
  output logic signed [mtu_pkg::DataW-1:0]    out_w
);

  localparam int unsigned N = mtu_pkg::EntryN;
  localparam int unsigned D = mtu_pkg::Dim;

  logic signed [mtu_pkg::DataW-1:0] cur   [N];
  logic signed [mtu_pkg::DataW-1:0] op    [N];
  logic signed [mtu_pkg::DataW-1:0] fresh [N];
  logic signed [mtu_pkg::DataW-1:0] vec   [D];
  logic signed [mtu_pkg::DataW-1:0] res   [D];
  logic signed [mtu_pkg::DataW-1:0] mul_a [D];
  logic signed [mtu_pkg::DataW-1:0] mul_b [D];
  logic signed [mtu_pkg::ProdW-1:0] prod  [D];
  logic signed [mtu_pkg::TermW-1:0] term  [D];
  logic signed [mtu_pkg::PairW-1:0] pair  [2];
  logic signed [mtu_pkg::AccW-1:0]  acc   [D];
  logic signed [mtu_pkg::AccW-1:0]  sum;
  logic m_valid, m_xform, m_first, m_last;
  logic p_valid, a_valid, a_last;

  // The current matrix rotates by one row per issue and the operand by one
  // entry per multiply issue, so the lanes always read fixed places and both return home.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      if (cmd.xform) begin
        mul_a[i] = cur[i];
        mul_b[i] = vec[i];
      end else begin
        mul_a[i] = op[0];
        mul_b[i] = cur[i];
      end
      term[i] = prod[i][mtu_pkg::ProdW-1:mtu_pkg::FracW];
    end
    sum = mtu_pkg::AccW'(pair[0]) + mtu_pkg::AccW'(pair[1]);
  end

  assign stat.busy = m_valid | p_valid | a_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        cur[k] <= ((k % (D + 1)) == 0) ? mtu_pkg::QOne : '0;
      end
    end else if (cmd.ident) begin
      for (int k = 0; k < N; k++) begin
        cur[k] <= ((k % (D + 1)) == 0) ? mtu_pkg::QOne : '0;
      end
    end else if (cmd.wr_cur) begin
      cur[entry_index] <= entry_value;
    end else if (cmd.issue) begin
      for (int k = 0; k < N; k++) begin
        cur[k] <= cur[(k + D) % N];
      end
    end else if (cmd.copy) begin
      for (int k = 0; k < N; k++) begin
        cur[k] <= fresh[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op) begin
      op[entry_index] <= entry_value;
    end else if (cmd.issue && !cmd.xform) begin
      for (int k = 0; k < N; k++) begin
        op[k] <= op[(k + 1) % N];
      end
    end
    if (cmd.load_vec) begin
      vec[0] <= vec_x;
      vec[1] <= vec_y;
      vec[2] <= vec_z;
      vec[3] <= vec_w;
    end
    if (cmd.issue) begin
      for (int i = 0; i < D; i++) begin
        prod[i] <= mul_a[i] * mul_b[i];
      end
    end
    m_xform <= cmd.xform;
    m_first <= cmd.first;
    m_last  <= cmd.last;
    a_last  <= m_last;
    if (m_valid && m_xform) begin
      pair[0] <= mtu_pkg::PairW'(term[0]) + mtu_pkg::PairW'(term[1]);
      pair[1] <= mtu_pkg::PairW'(term[2]) + mtu_pkg::PairW'(term[3]);
    end
    if (m_valid && !m_xform) begin
      for (int i = 0; i < D; i++) begin
        acc[i] <= m_first ? mtu_pkg::AccW'(term[i]) : acc[i] + mtu_pkg::AccW'(term[i]);
      end
    end
    if (p_valid) begin
      for (int i = 0; i < D - 1; i++) begin
        res[i] <= res[i + 1];
      end
      res[D-1] <= mtu_pkg::sat32(sum);
    end
    if (a_valid && a_last) begin
      for (int k = 0; k < N - D; k++) begin
        fresh[k] <= fresh[k + D];
      end
      for (int i = 0; i < D; i++) begin
        fresh[N - D + i] <= mtu_pkg::sat32(acc[i]);
      end
    end
    if (cmd.publish) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_w <= res[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      m_valid <= cmd.issue;
      p_valid <= m_valid & m_xform;
      a_valid <= m_valid & ~m_xform;
    end
  end

endmodule

### hdl/matrix_transform_unit_4x4.sv
// Top level of the 4x4 matrix transform unit.
// The unit takes one item at a time. Entry writes, identity loads and unused
// kinds are done as they are accepted. A vector transform issues one matrix
// row at a time through the four 32x32 multiplier lanes, then registers the
// pair sums and the saturated element, and then loads the output register.
// The result waits in the output register while the next item is already
// accepted. If the output register is still full when the next transform
// finishes, that transform holds until the register is free. A post-multiply
// issues one operand entry times one current row at a time, then drains the
// accumulators and copies the new matrix into place. Products are truncated
// to Q16.16 and each sum saturates to 32 bits.
module matrix_transform_unit_4x4 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        kind,
  input  logic [3:0]                        entry_index,
  input  logic signed [mtu_pkg::DataW-1:0]  entry_value,
  input  logic signed [mtu_pkg::DataW-1:0]  vec_x,
  input  logic signed [mtu_pkg::DataW-1:0]  vec_y,
  input  logic signed [mtu_pkg::DataW-1:0]  vec_z,
  input  logic signed [mtu_pkg::DataW-1:0]  vec_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mtu_pkg::DataW-1:0]  out_x,
  output logic signed [mtu_pkg::DataW-1:0]  out_y,
  output logic signed [mtu_pkg::DataW-1:0]  out_z,
  output logic signed [mtu_pkg::DataW-1:0]  out_w
);

  mtu_pkg::dp_cmd_t  cmd;
  mtu_pkg::dp_stat_t stat;

  mtu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mtu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .vec_w       (vec_w),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_w       (out_w)
  );

endmodule

### sim/tb_matrix_transform_unit_4x4.sv
// Self-checking testbench for the 4x4 matrix transform unit with a Q16.16 predictor.
module tb_matrix_transform_unit_4x4;
  import mtu_pkg::*;

  localparam int unsigned ItemTarget = 550;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned LongHold   = 80;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    logic signed [DataW-1:0] w;
  } vec4_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [3:0]              idx;
    logic signed [DataW-1:0] val;
    vec4_t                   v;
  } cmd_t;

  class xform_scoreboard;
    logic signed [DataW-1:0] cur [EntryN];
    logic signed [DataW-1:0] opnd [EntryN];
    vec4_t                   pending_outputs [$];
    int unsigned             errors;

    function new();
      errors = 0;
      load_identity();
      foreach (opnd[k]) opnd[k] = '0;
    endfunction

    function void load_identity();
      foreach (cur[k]) cur[k] = ((k % 5) == 0) ? QOne : '0;
    endfunction

    // Q16.16 product, floor-truncated, kept wide.
    function longint qmul(logic signed [DataW-1:0] a, logic signed [DataW-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FracW;
    endfunction

    function logic signed [DataW-1:0] clamp32(longint s);
      if (s > longint'(QMax)) return QMax;
      if (s < longint'(QMin)) return QMin;
      return DataW'(s);
    endfunction

    function void note_item(cmd_t c);
      logic signed [DataW-1:0] fresh [EntryN];
      logic signed [DataW-1:0] vin [Dim];
      logic signed [DataW-1:0] res [Dim];
      longint acc;
      case (c.kind)
        KIND_WR_CUR: cur[c.idx] = c.val;
        KIND_WR_OP:  opnd[c.idx] = c.val;
        KIND_MMUL: begin
          for (int r = 0; r < Dim; r++) begin
            for (int i = 0; i < Dim; i++) begin
              acc = 0;
              for (int j = 0; j < Dim; j++) acc += qmul(opnd[4*r+j], cur[4*j+i]);
              fresh[4*r+i] = clamp32(acc);
            end
          end
          cur = fresh;
        end
        KIND_XFORM: begin
          vin[0] = c.v.x;
          vin[1] = c.v.y;
          vin[2] = c.v.z;
          vin[3] = c.v.w;
          for (int i = 0; i < Dim; i++) begin
            acc = 0;
            for (int j = 0; j < Dim; j++) acc += qmul(cur[4*i+j], vin[j]);
            res[i] = clamp32(acc);
          end
          pending_outputs.push_back({res[0], res[1], res[2], res[3]});
        end
        KIND_IDENT: load_identity();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic signed [DataW-1:0] want,
                                logic signed [DataW-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(vec4_t got);
      vec4_t want;
      if (pending_outputs.size() == 0) begin
        $error("result with no item outstanding: %0d %0d %0d %0d",
               got.x, got.y, got.z, got.w);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("out_w", want.w, got.w);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        kind = '0;
  logic [3:0]        entry_index = '0;
  logic signed [DataW-1:0] entry_value = '0;
  logic signed [DataW-1:0] vec_x = '0;
  logic signed [DataW-1:0] vec_y = '0;
  logic signed [DataW-1:0] vec_z = '0;
  logic signed [DataW-1:0] vec_w = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [DataW-1:0] out_x;
  logic signed [DataW-1:0] out_y;
  logic signed [DataW-1:0] out_z;
  logic signed [DataW-1:0] out_w;

  xform_scoreboard sb = new();
  int unsigned     issued = 0;
  int unsigned     results_seen = 0;
  int unsigned     quiet_cycles = 0;

  matrix_transform_unit_4x4 u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .vec_w       (vec_w),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_w       (out_w)
  );

  always #4 clk = ~clk;

  // Mostly modest magnitudes so that sums do not always saturate.
  function automatic logic signed [DataW-1:0] rand_q();
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1:       return QMax;
      2:       return QMin;
      3:       return '0;
      default: return int'($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] k, logic [3:0] i, logic signed [DataW-1:0] val,
                                    logic signed [DataW-1:0] x, logic signed [DataW-1:0] y,
                                    logic signed [DataW-1:0] z, logic signed [DataW-1:0] w);
    cmd_t c;
    c.kind = k;
    c.idx  = i;
    c.val  = val;
    c.v    = {x, y, z, w};
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    int unsigned pick;
    logic [2:0]  k;
    pick = $urandom_range(0, 99);
    if (pick < 55)      k = KIND_XFORM;
    else if (pick < 70) k = KIND_WR_CUR;
    else if (pick < 80) k = KIND_WR_OP;
    else if (pick < 86) k = KIND_MMUL;
    else if (pick < 90) k = KIND_IDENT;
    else                k = 3'($urandom_range(5, 7));
    return make_cmd(k, 4'($urandom), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
  endfunction

  task automatic issue_cmd(cmd_t c);
    int unsigned gap;
    gap = (((issued / 40) % 4) == 3) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= c.kind;
    entry_index <= c.idx;
    entry_value <= c.val;
    vec_x       <= c.v.x;
    vec_y       <= c.v.y;
    vec_z       <= c.v.z;
    vec_w       <= c.v.w;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c);
    issued++;
  endtask

  task automatic directed_cmds();
    issue_cmd(make_cmd(KIND_XFORM, '0, '0, QMax, QMin, '0, -32'sd1));
    // Operand rows 0 and 1 at the extremes so the product reaches both ends of the range.
    for (int k = 0; k < EntryN; k++) begin
      issue_cmd(make_cmd(KIND_WR_OP, 4'(k), (k < 4) ? QMax : (k < 8) ? QMin : rand_q(),
                         '0, '0, '0, '0));
    end
    issue_cmd(make_cmd(KIND_MMUL, '0, '0, '0, '0, '0, '0));
    issue_cmd(make_cmd(KIND_XFORM, '0, '0, QMax, QMax, QMax, QMax));
    issue_cmd(make_cmd(KIND_WR_CUR, 4'd15, QMin, '0, '0, '0, '0));
    issue_cmd(make_cmd(KIND_WR_CUR, 4'd0, '0, '0, '0, '0, '0));
    issue_cmd(make_cmd(KIND_XFORM, '0, '0, QMin, QMin, QMin, QMin));
    issue_cmd(make_cmd(3'd5, 4'd15, QMax, QMin, QMax, QMin, QMax));
    issue_cmd(make_cmd(3'd7, 4'd10, QMin, QMax, QMin, QMax, QMin));
    issue_cmd(make_cmd(KIND_IDENT, '0, '0, '0, '0, '0, '0));
    issue_cmd(make_cmd(KIND_XFORM, '0, '0, QOne, -QOne, QMax, QMin));
  endtask

  initial begin
    cmd_t        c;
    bit          paused;
    paused  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_cmds();
    while (issued < ItemTarget) begin
      c = random_cmd();
      if (!paused && issued == ItemTarget / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_outputs.size() != 0);
      end
      issue_cmd(c);
    end
    in_valid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_matrix_transform_unit_4x4: done, clean");
    end else begin
      $display("tb_matrix_transform_unit_4x4: done, errors");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (!rst);
    forever begin
      stall = (((results_seen / 30) % 4) == 2) ? 0 : $urandom_range(0, 3);
      if (results_seen == 150) stall = LongHold;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result({out_x, out_y, out_z, out_w});
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("tb_matrix_transform_unit_4x4: done, errors");
        $finish;
      end
    end
  end

endmodule
